>>> rtl/efp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_pkg
// Shared types, constants and the Q4.28 saturation helper for the
// escape-time pixel core.
// ----------------------------------------------------------------------------
package efp_pkg;

    localparam int FRAC_BITS = 28;

    localparam logic [2:0] CFG_STEP_RE   = 3'd0;
    localparam logic [2:0] CFG_STEP_IM   = 3'd1;
    localparam logic [2:0] CFG_OFFSET_RE = 3'd2;
    localparam logic [2:0] CFG_OFFSET_IM = 3'd3;
    localparam logic [2:0] CFG_MAX_ITER  = 3'd4;

    localparam logic signed [31:0] Q_ONE     = 32'sh1000_0000;
    localparam logic signed [63:0] Q_MAX     = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] Q_MIN     = -64'sh0000_0000_8000_0000;
    localparam logic [63:0]        ESC_LIMIT = 64'h0400_0000_0000_0000;

    typedef enum logic [2:0] {
        OP_MAP_RE,
        OP_MAP_IM,
        OP_SQX,
        OP_SQY,
        OP_XY
    } t_op;

    typedef struct packed {
        logic [9:0]         px;
        logic [9:0]         py;
        logic [30:0]        step_re;
        logic [30:0]        step_im;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_mul_src;

    function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > Q_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < Q_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/escape_time_fractal_pixel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_core
// Maps a pixel to a point c and iterates z = z*z + c from z = i on one
// shared multiplier until |z|^2 > 4 or the iteration limit is reached.
// one item at a time: busy stays high from the accepting edge until the result strobe
// three multiplier products (x*x, y*y, x*y) per iteration
// the next item can be accepted in the cycle that carries the strobe
// i_rst_n (sync, active low) returns to idle and loads the register defaults
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_core #(
    parameter int WIDTH  = 1024,
    parameter int HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [9:0]  i_pixel_x,
    input  logic [9:0]  i_pixel_y,
    output logic        o_valid,
    output logic [9:0]  o_out_x,
    output logic [9:0]  o_out_y,
    output logic [15:0] o_iter_count,
    output logic        o_escaped
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_IM,
        S_SQX,
        S_SQY,
        S_XY,
        S_UPD
    } t_state;

    t_state             r_state;
    logic [30:0]        r_step_re;
    logic [30:0]        r_step_im;
    logic signed [31:0] r_offset_re;
    logic signed [31:0] r_offset_im;
    logic [15:0]        r_max_iter;

    logic [9:0]         r_px;
    logic [9:0]         r_py;
    logic signed [31:0] r_c_re;
    logic signed [31:0] r_c_im;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [63:0] r_xx;
    logic signed [63:0] r_yy;
    logic [15:0]        r_count;

    logic               r_valid;
    logic [9:0]         r_out_x;
    logic [9:0]         r_out_y;
    logic [15:0]        r_out_count;
    logic               r_escaped;

    efp_pkg::t_op       w_op;
    efp_pkg::t_mul_src  w_src;
    logic signed [63:0] w_prod;
    logic [63:0]        w_mag;
    logic               w_stop;
    logic signed [63:0] w_nx;
    logic signed [63:0] w_ny;
    logic signed [63:0] w_map_re;
    logic signed [63:0] w_map_im;

    always_comb begin
        unique case (r_state)
            S_IDLE:   w_op = efp_pkg::OP_MAP_RE;
            S_MAP_IM: w_op = efp_pkg::OP_MAP_IM;
            S_SQX:    w_op = efp_pkg::OP_SQX;
            S_SQY:    w_op = efp_pkg::OP_SQY;
            S_XY:     w_op = efp_pkg::OP_XY;
            S_UPD:    w_op = efp_pkg::OP_SQX;
            default:  w_op = efp_pkg::OP_SQX;
        endcase
    end

    assign w_src.px      = (r_state == S_IDLE) ? i_pixel_x : r_px;
    assign w_src.py      = r_py;
    assign w_src.step_re = r_step_re;
    assign w_src.step_im = r_step_im;
    assign w_src.x       = r_x;
    assign w_src.y       = r_y;

    efp_mul #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_mul (
        .i_clk  (i_clk),
        .i_op   (w_op),
        .i_src  (w_src),
        .o_prod (w_prod)
    );

    // escape test and next z
    assign w_mag    = 64'(r_xx) + 64'(r_yy);
    assign w_stop   = (r_count >= r_max_iter) || (w_mag > efp_pkg::ESC_LIMIT);
    assign w_nx     = ((r_xx - r_yy) >>> efp_pkg::FRAC_BITS) + 64'(r_c_re);
    assign w_ny     = (w_prod >>> (efp_pkg::FRAC_BITS - 1)) + 64'(r_c_im);
    assign w_map_re = w_prod + 64'(r_offset_re);
    assign w_map_im = w_prod + 64'(r_offset_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_step_re   <= 31'd1048576;
            r_step_im   <= 31'd1048576;
            r_offset_re <= '0;
            r_offset_im <= '0;
            r_max_iter  <= 16'd50;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    efp_pkg::CFG_STEP_RE:   r_step_re   <= i_cfg_data[30:0];
                    efp_pkg::CFG_STEP_IM:   r_step_im   <= i_cfg_data[30:0];
                    efp_pkg::CFG_OFFSET_RE: r_offset_re <= $signed(i_cfg_data);
                    efp_pkg::CFG_OFFSET_IM: r_offset_im <= $signed(i_cfg_data);
                    efp_pkg::CFG_MAX_ITER:  r_max_iter  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_px    <= i_pixel_x;
                        r_py    <= i_pixel_y;
                        r_x     <= '0;
                        r_y     <= efp_pkg::Q_ONE;
                        r_count <= '0;
                        r_state <= S_MAP_IM;
                    end
                end
                S_MAP_IM: begin
                    r_c_re  <= efp_pkg::sat_q(w_map_re);
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    // mapped imaginary product is only on the bus in the first pass
                    if (r_count == '0) begin
                        r_c_im <= efp_pkg::sat_q(w_map_im);
                    end
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_xx    <= w_prod;
                    r_state <= S_XY;
                end
                S_XY: begin
                    r_yy    <= w_prod;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_stop) begin
                        r_valid     <= 1'b1;
                        r_out_x     <= r_px;
                        r_out_y     <= r_py;
                        r_out_count <= r_count;
                        r_escaped   <= (r_count < r_max_iter);
                        r_state     <= S_IDLE;
                    end else begin
                        r_x     <= efp_pkg::sat_q(w_nx);
                        r_y     <= efp_pkg::sat_q(w_ny);
                        r_count <= r_count + 16'd1;
                        r_state <= S_SQX;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_iter_count = r_out_count;
    assign o_escaped    = r_escaped;

endmodule

>>> rtl/efp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_mul
// Shared signed multiplier with operand select and registered product,
// used for the point mapping and for the three products of each iteration.
// ----------------------------------------------------------------------------
module efp_mul #(
    parameter int WIDTH  = 1024,
    parameter int HEIGHT = 1024
) (
    input  logic                i_clk,
    input  efp_pkg::t_op        i_op,
    input  efp_pkg::t_mul_src   i_src,
    output logic signed [63:0]  o_prod
);

    localparam logic signed [32:0] HalfW = 33'(WIDTH / 2);
    localparam logic signed [32:0] HalfH = 33'(HEIGHT / 2);

    logic signed [32:0] w_a;
    logic signed [32:0] w_b;
    logic signed [65:0] w_full;
    logic signed [63:0] r_prod;

    always_comb begin
        unique case (i_op)
            efp_pkg::OP_MAP_RE: begin
                w_a = $signed({23'd0, i_src.px}) - HalfW;
                w_b = $signed({2'b00, i_src.step_re});
            end
            efp_pkg::OP_MAP_IM: begin
                w_a = $signed({23'd0, i_src.py}) - HalfH;
                w_b = $signed({2'b00, i_src.step_im});
            end
            efp_pkg::OP_SQX: begin
                w_a = {i_src.x[31], i_src.x};
                w_b = {i_src.x[31], i_src.x};
            end
            efp_pkg::OP_SQY: begin
                w_a = {i_src.y[31], i_src.y};
                w_b = {i_src.y[31], i_src.y};
            end
            efp_pkg::OP_XY: begin
                w_a = {i_src.x[31], i_src.x};
                w_b = {i_src.y[31], i_src.y};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_full = w_a * w_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[63:0];
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/efp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_chk
// Port-level checks on the start/busy/strobe sequencing of the pixel core.
// ----------------------------------------------------------------------------
module efp_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted item did not raise busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("item finished without a result");

endmodule

bind escape_time_fractal_pixel_core efp_chk u_efp_chk (.*);

>>> test/escape_time_fractal_pixel_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_core_tb
// Self-checking bench for the escape-time pixel core. A driver feeds pixel
// items from a queue over the start/busy handshake, a predictor computes the
// iteration count and escape flag for each accepted item from its own copy of
// the window registers, and a monitor compares every strobed result against
// the oldest prediction. Directed corner cases come first, then random
// windows and pixels under several sender idle rates.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_core_tb;

    localparam int HALF_W = 512;
    localparam int HALF_H = 512;

    typedef struct packed {
        logic [9:0] px;
        logic [9:0] py;
    } t_pixel_item;

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [15:0] count;
        logic        escaped;
    } t_pixel_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [9:0]  i_pixel_x = '0;
    logic [9:0]  i_pixel_y = '0;
    logic        o_valid;
    logic [9:0]  o_out_x;
    logic [9:0]  o_out_y;
    logic [15:0] o_iter_count;
    logic        o_escaped;

    // window registers as the core should hold them
    logic [30:0]        win_step_re = 31'd1048576;
    logic [30:0]        win_step_im = 31'd1048576;
    logic signed [31:0] win_offset_re = '0;
    logic signed [31:0] win_offset_im = '0;
    logic [15:0]        win_max_iter = 16'd50;

    t_pixel_item   pixel_q[$];
    t_pixel_result escape_q[$];
    int            pixels_waiting = 0;
    int            send_idle_pct = 0;
    int            mismatch_count = 0;
    bit            accepted;
    t_pixel_item   next_pixel;
    t_pixel_result seen;
    t_pixel_result want;

    escape_time_fractal_pixel_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .start        (start),
        .busy         (busy),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .o_valid      (o_valid),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_iter_count (o_iter_count),
        .o_escaped    (o_escaped)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint clamp_q(input longint v);
        longint r;
        if (v > efp_pkg::Q_MAX) begin
            r = efp_pkg::Q_MAX;
        end else if (v < efp_pkg::Q_MIN) begin
            r = efp_pkg::Q_MIN;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic t_pixel_result predict_escape(input logic [9:0] px,
                                                     input logic [9:0] py,
                                                     input logic [15:0] limit);
        t_pixel_result r;
        longint        c_re;
        longint        c_im;
        longint        zr;
        longint        zi;
        longint        nr;
        logic [63:0]   sq_r;
        logic [63:0]   sq_i;
        int unsigned   n;
        c_re = clamp_q((longint'(px) - HALF_W) * longint'(win_step_re)
                       + longint'(win_offset_re));
        c_im = clamp_q((longint'(py) - HALF_H) * longint'(win_step_im)
                       + longint'(win_offset_im));
        zr = 0;
        zi = longint'(1) << efp_pkg::FRAC_BITS;
        n = 0;
        while (n < limit) begin
            sq_r = zr * zr;
            sq_i = zi * zi;
            if (sq_r + sq_i > efp_pkg::ESC_LIMIT) break;
            nr = clamp_q(((zr * zr - zi * zi) >>> efp_pkg::FRAC_BITS) + c_re);
            zi = clamp_q(((zr * zi) >>> (efp_pkg::FRAC_BITS - 1)) + c_im);
            zr = nr;
            n++;
        end
        r.x = px;
        r.y = py;
        r.count = n[15:0];
        r.escaped = (n < limit);
        return r;
    endfunction

    // driver: start stays high until the core takes the item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            accepted = start && !busy;
            if (accepted) begin
                escape_q.push_back(predict_escape(i_pixel_x, i_pixel_y, win_max_iter));
                pixels_waiting--;
            end
            if (accepted || !start) begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_pixel = pixel_q.pop_front();
                    start     <= 1'b1;
                    i_pixel_x <= next_pixel.px;
                    i_pixel_y <= next_pixel.py;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen = '{o_out_x, o_out_y, o_iter_count, o_escaped};
            if (escape_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result x=%0d y=%0d count=%0d escaped=%0b",
                             seen.x, seen.y, seen.count, seen.escaped);
                end
            end else begin
                want = escape_q.pop_front();
                if (seen.x !== want.x || seen.y !== want.y ||
                    seen.count !== want.count || seen.escaped !== want.escaped) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected x=%0d y=%0d count=%0d escaped=%0b",
                                 want.x, want.y, want.count, want.escaped);
                        $display("          actual   x=%0d y=%0d count=%0d escaped=%0b",
                                 seen.x, seen.y, seen.count, seen.escaped);
                    end
                end
            end
        end
    end

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            efp_pkg::CFG_STEP_RE:   win_step_re = value[30:0];
            efp_pkg::CFG_STEP_IM:   win_step_im = value[30:0];
            efp_pkg::CFG_OFFSET_RE: win_offset_re = value;
            efp_pkg::CFG_OFFSET_IM: win_offset_im = value;
            efp_pkg::CFG_MAX_ITER:  win_max_iter = value[15:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
        pixel_q.push_back('{px, py});
        pixels_waiting++;
    endtask

    task automatic wait_drain();
        while (pixels_waiting != 0 || escape_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_step();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) begin
            return $urandom_range(1 << 22, 1 << 16) | (32'($urandom_range(1)) << 31);
        end else if (sel < 85) begin
            return $urandom_range(255);
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_offset();
        if ($urandom_range(99) < 70) begin
            return $urandom_range(1 << 29) - (1 << 28);
        end
        return $urandom;
    endfunction

    task automatic randomize_window();
        int          sel;
        logic [15:0] limit;
        sel = $urandom_range(99);
        if (sel < 80) begin
            limit = 16'($urandom_range(40, 1));
        end else if (sel < 95) begin
            limit = 16'($urandom_range(200, 41));
        end else begin
            limit = 16'($urandom_range(1));
        end
        set_reg(efp_pkg::CFG_STEP_RE, pick_step());
        set_reg(efp_pkg::CFG_STEP_IM, pick_step());
        set_reg(efp_pkg::CFG_OFFSET_RE, pick_offset());
        set_reg(efp_pkg::CFG_OFFSET_IM, pick_offset());
        set_reg(efp_pkg::CFG_MAX_ITER, {16'($urandom), limit});
    endtask

    initial begin : run_limit
        #64_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int            idle_plan[4];
        t_pixel_result probe;
        logic [9:0]    px;
        logic [9:0]    py;
        bit            found;
        idle_plan = '{0, 50, 0, 16};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window: corners, center, alternating bits
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd511, 10'd513);
        send_pixel(10'h2AA, 10'h155);
        send_pixel(10'h155, 10'h2AA);
        wait_drain();

        // zero iteration limit
        set_reg(efp_pkg::CFG_MAX_ITER, 32'd0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);
        wait_drain();

        // largest limit, one point that never escapes
        set_reg(efp_pkg::CFG_MAX_ITER, 32'h0000_FFFF);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);
        wait_drain();

        // saturation of the mapped point
        set_reg(efp_pkg::CFG_STEP_RE, 32'h7FFF_FFFF);
        set_reg(efp_pkg::CFG_STEP_IM, 32'hFFFF_FFFF);
        set_reg(efp_pkg::CFG_OFFSET_RE, 32'h7FFF_FFFF);
        set_reg(efp_pkg::CFG_OFFSET_IM, 32'h8000_0000);
        set_reg(efp_pkg::CFG_MAX_ITER, 32'd20);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd512, 10'd512);
        wait_drain();

        // zero step maps every pixel to the offsets
        set_reg(efp_pkg::CFG_STEP_RE, 32'h8000_0000);
        set_reg(efp_pkg::CFG_STEP_IM, 32'd0);
        set_reg(efp_pkg::CFG_OFFSET_RE, 32'hF000_0000);
        set_reg(efp_pkg::CFG_OFFSET_IM, 32'h0400_0000);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        wait_drain();

        // iteration limit set to the count at which a probed point escapes
        set_reg(efp_pkg::CFG_STEP_RE, 32'd1048576);
        set_reg(efp_pkg::CFG_STEP_IM, 32'd1048576);
        set_reg(efp_pkg::CFG_OFFSET_RE, 32'd0);
        set_reg(efp_pkg::CFG_OFFSET_IM, 32'd0);
        found = 1'b0;
        px = 10'd0;
        py = 10'd0;
        repeat (200) begin
            if (!found) begin
                px = 10'($urandom_range(1023));
                py = 10'($urandom_range(1023));
                probe = predict_escape(px, py, 16'd1000);
                found = probe.escaped && probe.count > 2;
            end
        end
        if (!found) begin
            px = 10'd0;
            py = 10'd0;
            probe = predict_escape(px, py, 16'd1000);
        end
        set_reg(efp_pkg::CFG_MAX_ITER, 32'(probe.count));
        send_pixel(px, py);
        wait_drain();

        // random windows under different sender idle rates
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_plan[ph];
            repeat (3) begin
                wait_drain();
                randomize_window();
                repeat (100) begin
                    if ($urandom_range(99) < 80) begin
                        send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)));
                    end else begin
                        send_pixel(10'(480 + $urandom_range(64)),
                                   10'(480 + $urandom_range(64)));
                    end
                end
            end
        end
        wait_drain();
        repeat (4 * int'(win_max_iter) + 16) @(posedge i_clk);

        if (mismatch_count == 0 && escape_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
